### hdl/nmf_pkg.sv
// ============================================================================
// nmf_pkg - shared definitions for the 3x3 neighbour mean filter
// Field widths, register indexes, divider transaction types and the small
// helper functions that the modules of the filter use.
// ============================================================================
package nmf_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W    = 16;
    localparam int OUT_ROW_W   = 10;
    localparam int OUT_COL_W   = 5;
    localparam int MEAN_W      = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;

    // Configuration port.
    localparam int ROW_CFG_W   = 11;
    localparam int COL_CFG_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    // Default sizes handed to the top level parameters.
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 1024;

    // Neighbour sum of up to eight samples and the neighbour count.
    localparam int SUM_W = SAMPLE_W + 3;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_CORNER = 4'd3;
    localparam logic [CNT_W-1:0] CNT_EDGE   = 4'd5;
    localparam logic [CNT_W-1:0] CNT_INNER  = 4'd8;

    // Reciprocals for division by 3 and by 5, scaled by 2**RECIP_SHIFT.
    // Both are exact for every magnitude a corner or edge sum can reach.
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP3 = 19'd349526;
    localparam logic [RECIP_W-1:0] RECIP5 = 19'd209716;
    localparam int QUOT_W = 17;
    localparam int REM_W  = 3;
    localparam int FRAC_W = 16;

    // Ring slot of one of the three buffered rows.
    typedef logic [1:0] t_ring;

    // Divider request and response.
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } t_div_req;

    typedef struct packed {
        logic                     valid;
        logic signed [MEAN_W-1:0] mean;
    } t_div_rsp;

    // Next ring slot, modulo three.
    function automatic t_ring ring_inc(input t_ring slot);
        ring_inc = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    endfunction

    // Previous ring slot, modulo three.
    function automatic t_ring ring_dec(input t_ring slot);
        ring_dec = (slot == 2'd0) ? 2'd2 : slot - 2'd1;
    endfunction

    // Fraction part floor((rem * 65536 + cnt/2) / cnt) for divisors 3 and 5.
    function automatic logic [FRAC_W-1:0] frac_lut(input logic by5,
                                                   input logic [REM_W-1:0] rem);
        case ({by5, rem})
            4'b0_001: frac_lut = 16'd21845;
            4'b0_010: frac_lut = 16'd43691;
            4'b1_001: frac_lut = 16'd13107;
            4'b1_010: frac_lut = 16'd26214;
            4'b1_011: frac_lut = 16'd39322;
            4'b1_100: frac_lut = 16'd52429;
            default:  frac_lut = 16'd0;
        endcase
    endfunction

endpackage

### hdl/nmf_row_mem.sv
// ============================================================================
// nmf_row_mem - three-row sample store
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ============================================================================
module nmf_row_mem
    import nmf_pkg::*;
#(
    parameter int DEPTH = 3 * MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0]        i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0]        o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nmf_mean_div.sv
// ============================================================================
// nmf_mean_div - rounded neighbour mean
// Three-stage pipeline that turns a neighbour sum and a count of 3, 5 or 8
// into sum * 65536 / count, rounded to nearest with ties away from zero.
// Division by 3 and 5 uses a reciprocal multiply and a remainder lookup.
// ============================================================================
module nmf_mean_div
    import nmf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int ABS_W  = SUM_W;
    localparam int PROD_W = ABS_W + RECIP_W;
    localparam int MAG_W  = MEAN_W + 1;

    // Stage 1: magnitude and reciprocal product.
    logic                  r_v1, n_v1;
    logic                  r_neg1;
    logic [ABS_W-1:0]      r_abs1;
    logic [CNT_W-1:0]      r_cnt1;
    logic [PROD_W-1:0]     r_prod1;
    logic [ABS_W-1:0]      abs_in;
    logic [RECIP_W-1:0]    recip;

    // Stage 2: quotient and remainder.
    logic                  r_v2, n_v2;
    logic                  r_neg2;
    logic [ABS_W-1:0]      r_abs2;
    logic [CNT_W-1:0]      r_cnt2;
    logic [QUOT_W-1:0]     r_quot2;
    logic [REM_W-1:0]      r_rem2;
    logic [QUOT_W-1:0]     quot;
    logic [QUOT_W+2:0]     quot_x;

    // Stage 3: composed result.
    logic                  r_v3, n_v3;
    logic [MEAN_W-1:0]     r_mean3;
    logic [MAG_W-1:0]      mag;
    logic [MAG_W-1:0]      signed_mag;

    assign abs_in = i_req.sum[SUM_W-1] ? ABS_W'(-i_req.sum) : ABS_W'(i_req.sum);
    assign recip  = (i_req.cnt == CNT_EDGE) ? RECIP5 : RECIP3;

    // Quotient estimate and quotient times divisor by shift and add.
    assign quot   = r_prod1[RECIP_SHIFT +: QUOT_W];
    assign quot_x = (r_cnt1 == CNT_EDGE)
                  ? ({1'b0, quot, 2'b00} + {3'b000, quot})
                  : ({2'b00, quot, 1'b0} + {3'b000, quot});

    // Whole part, fraction from the remainder, then the sign.
    always_comb begin
        if (r_cnt2 == CNT_INNER) begin
            mag = MAG_W'({r_abs2, 13'd0});
        end else begin
            mag = MAG_W'({r_quot2, 16'd0})
                + MAG_W'(frac_lut(r_cnt2 == CNT_EDGE, r_rem2));
        end
        signed_mag = r_neg2 ? (~mag + MAG_W'(1)) : mag;
    end

    assign n_v1 = i_req.valid;
    assign n_v2 = r_v1;
    assign n_v3 = r_v2;

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // Pipeline data.
    always_ff @(posedge i_clk) begin
        r_neg1  <= i_req.sum[SUM_W-1];
        r_abs1  <= abs_in;
        r_cnt1  <= i_req.cnt;
        r_prod1 <= abs_in * recip;
        r_neg2  <= r_neg1;
        r_abs2  <= r_abs1;
        r_cnt2  <= r_cnt1;
        r_quot2 <= quot;
        r_rem2  <= REM_W'(r_abs1 - ABS_W'(quot_x));
        r_mean3 <= signed_mag[MEAN_W-1:0];
    end

    assign o_rsp.valid = r_v3;
    assign o_rsp.mean  = r_mean3;

endmodule

### hdl/neighbour_mean_filter_3x3.sv
// ============================================================================
// neighbour_mean_filter_3x3 - 3x3 neighbour mean over a raster stream
// Averages the existing 8-neighbours of each element, center excluded, and
// returns the result as signed fixed point with 16 fraction bits.
// ============================================================================
//
// Usage:
//   Samples enter on the s_axis channel in raster order, one element per
//   transaction. Each sample is written to a three-row ring store; results
//   for the row above come out one row and one column behind. The frame's
//   last sample also produces the whole final row. Results leave on the
//   m_axis channel; tlast marks the last result caused by one sample and
//   tuser marks the result for the frame's last element.
//   Row and column counts are written on the cfg port while the block is
//   idle; a write restarts the frame at element (0, 0).
// Timing:
//   One sample occupies the block until its last result is in the output
//   register. Each result takes up to eight reads from the single read
//   port of the row store, one per cycle, followed by the three-stage
//   divider. A sample causes zero, one, two or up to MAX_COLS + 2 results.
// Reset and stall:
//   Reset clears the positions, the configuration (2 rows, 2 columns) and
//   the output register. A stalled receiver holds the output register; the
//   next sample is still taken while a finished result waits there.
//
module neighbour_mean_filter_3x3
    import nmf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [15:0] sample
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [9:0] out_row, [14:10] out_col,
                                                   // [46:15] neighbour_mean, [47] zero
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser    // [0] frame_done
);

    localparam int DEPTH  = 3 * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PICK  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_GO    = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Control registers.
    logic [2:0]              r_state, n_state;
    logic [ROW_CFG_W-1:0]    r_row_count, n_row_count;
    logic [COL_CFG_W-1:0]    r_col_count, n_col_count;
    logic [ROW_W-1:0]        r_row_pos, n_row_pos;
    logic [COL_W-1:0]        r_col_pos, n_col_pos;
    t_ring                   r_ring, n_ring;
    logic                    r_pend_a, n_pend_a;
    logic                    r_pend_b, n_pend_b;
    logic                    r_pend_c, n_pend_c;
    logic                    r_rd_vld, n_rd_vld;
    logic                    r_m_valid, n_m_valid;

    // Data registers.
    logic [ROW_W-1:0]        r_in_row, n_in_row;
    logic [COL_W-1:0]        r_in_col, n_in_col;
    t_ring                   r_in_ring, n_in_ring;
    logic [COL_W-1:0]        r_jcol, n_jcol;
    logic [ROW_W-1:0]        r_job_row, n_job_row;
    logic [COL_W-1:0]        r_job_col, n_job_col;
    t_ring                   r_job_ring, n_job_ring;
    logic                    r_job_last, n_job_last;
    logic                    r_job_done, n_job_done;
    logic [1:0]              r_di, n_di;
    logic [1:0]              r_dj, n_dj;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [MEAN_W-1:0]       r_mean, n_mean;
    logic [M_TDATA_W-1:0]    r_m_data, n_m_data;
    logic                    r_m_last, n_m_last;
    logic                    r_m_user, n_m_user;

    // Combinational helpers.
    logic [ROW_W-1:0]        last_row;
    logic [COL_W-1:0]        last_col;
    logic                    s_accept;
    logic                    out_free;
    logic                    row_ok;
    logic                    col_ok;
    logic                    rd_en;
    t_ring                   rd_ring;
    logic [COL_W-1:0]        rd_col;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [SAMPLE_W-1:0]     rd_data;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    // Start address of one ring slot in the row store.
    function automatic logic [ADDR_W-1:0] ring_base(input t_ring slot);
        case (slot)
            2'd0:    ring_base = '0;
            2'd1:    ring_base = ADDR_W'(MAX_COLS);
            default: ring_base = ADDR_W'(2 * MAX_COLS);
        endcase
    endfunction

    // Effective frame size, clamped to the supported range.
    always_comb begin
        if (r_row_count < 11'd2) begin
            last_row = ROW_W'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_row_count - 11'd1);
        end
        if (r_col_count < 6'd2) begin
            last_col = COL_W'(1);
        end else if (32'(r_col_count) > MAX_COLS) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(r_col_count - 6'd1);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign wr_addr       = ring_base(r_ring) + ADDR_W'(r_col_pos);

    // Neighbour window position: bounds check and read address.
    always_comb begin
        case (r_di)
            2'd0:    row_ok = (r_job_row != '0);
            2'd2:    row_ok = (r_job_row != last_row);
            default: row_ok = 1'b1;
        endcase
        case (r_dj)
            2'd0:    col_ok = (r_job_col != '0);
            2'd2:    col_ok = (r_job_col != last_col);
            default: col_ok = 1'b1;
        endcase
        case (r_di)
            2'd0:    rd_ring = ring_dec(r_job_ring);
            2'd2:    rd_ring = ring_inc(r_job_ring);
            default: rd_ring = r_job_ring;
        endcase
        case (r_dj)
            2'd0:    rd_col = r_job_col - COL_W'(1);
            2'd2:    rd_col = r_job_col + COL_W'(1);
            default: rd_col = r_job_col;
        endcase
        rd_addr = ring_base(rd_ring) + ADDR_W'(rd_col);
        rd_en   = (r_state == ST_SCAN) && row_ok && col_ok
               && !((r_di == 2'd1) && (r_dj == 2'd1));
    end

    // Sequencer: accept a sample, then walk through the results it causes.
    always_comb begin
        n_state     = r_state;
        n_row_count = r_row_count;
        n_col_count = r_col_count;
        n_row_pos   = r_row_pos;
        n_col_pos   = r_col_pos;
        n_ring      = r_ring;
        n_pend_a    = r_pend_a;
        n_pend_b    = r_pend_b;
        n_pend_c    = r_pend_c;
        n_rd_vld    = rd_en;
        n_m_valid   = r_m_valid;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_in_ring   = r_in_ring;
        n_jcol      = r_jcol;
        n_job_row   = r_job_row;
        n_job_col   = r_job_col;
        n_job_ring  = r_job_ring;
        n_job_last  = r_job_last;
        n_job_done  = r_job_done;
        n_di        = r_di;
        n_dj        = r_dj;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_mean      = r_mean;
        n_m_data    = r_m_data;
        n_m_last    = r_m_last;
        n_m_user    = r_m_user;

        // The receiver drains the output register.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        // Read data arrives in the cycle after its address.
        if (r_rd_vld) begin
            n_sum = r_sum + {{(SUM_W - SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
        end
        if (rd_en) begin
            n_cnt = r_cnt + CNT_W'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_in_row  = r_row_pos;
                    n_in_col  = r_col_pos;
                    n_in_ring = r_ring;
                    n_pend_a  = (r_row_pos != '0) && (r_col_pos != '0);
                    n_pend_b  = (r_row_pos != '0) && (r_col_pos == last_col);
                    n_pend_c  = (r_row_pos == last_row) && (r_col_pos == last_col);
                    n_jcol    = '0;
                    if (r_col_pos == last_col) begin
                        n_col_pos = '0;
                        if (r_row_pos == last_row) begin
                            n_row_pos = '0;
                            n_ring    = 2'd0;
                        end else begin
                            n_row_pos = r_row_pos + ROW_W'(1);
                            n_ring    = ring_inc(r_ring);
                        end
                    end else begin
                        n_col_pos = r_col_pos + COL_W'(1);
                    end
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_di       = 2'd0;
                n_dj       = 2'd0;
                n_sum      = '0;
                n_cnt      = '0;
                n_job_done = 1'b0;
                n_state    = ST_SCAN;
                if (r_pend_a) begin
                    n_pend_a   = 1'b0;
                    n_job_row  = r_in_row - ROW_W'(1);
                    n_job_col  = r_in_col - COL_W'(1);
                    n_job_ring = ring_dec(r_in_ring);
                    n_job_last = !r_pend_b && !r_pend_c;
                end else if (r_pend_b) begin
                    n_pend_b   = 1'b0;
                    n_job_row  = r_in_row - ROW_W'(1);
                    n_job_col  = last_col;
                    n_job_ring = ring_dec(r_in_ring);
                    n_job_last = !r_pend_c;
                end else if (r_pend_c) begin
                    n_job_row  = r_in_row;
                    n_job_col  = r_jcol;
                    n_job_ring = r_in_ring;
                    n_job_last = (r_jcol == last_col);
                    n_job_done = (r_jcol == last_col);
                    n_jcol     = r_jcol + COL_W'(1);
                    if (r_jcol == last_col) begin
                        n_pend_c = 1'b0;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_dj == 2'd2) begin
                    n_dj = 2'd0;
                    if (r_di == 2'd2) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_di = r_di + 2'd1;
                    end
                end else begin
                    n_dj = r_dj + 2'd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_GO;
            end
            ST_GO: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_rsp.valid) begin
                    n_mean  = div_rsp.mean;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {1'b0, r_mean, OUT_COL_W'(r_job_col),
                                 OUT_ROW_W'(r_job_row)};
                    n_m_last  = r_job_last;
                    n_m_user  = r_job_done;
                    n_state   = ST_PICK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Register writes restart the frame.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_COUNT: begin
                    n_row_count = i_cfg_wdata[ROW_CFG_W-1:0];
                    n_row_pos   = '0;
                    n_col_pos   = '0;
                    n_ring      = 2'd0;
                end
                CFG_COL_COUNT: begin
                    n_col_count = i_cfg_wdata[COL_CFG_W-1:0];
                    n_row_pos   = '0;
                    n_col_pos   = '0;
                    n_ring      = 2'd0;
                end
                default: begin
                    n_row_pos = r_row_pos;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_count <= ROW_CFG_W'(2);
            r_col_count <= COL_CFG_W'(2);
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_ring      <= 2'd0;
            r_pend_a    <= 1'b0;
            r_pend_b    <= 1'b0;
            r_pend_c    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_col_count <= n_col_count;
            r_row_pos   <= n_row_pos;
            r_col_pos   <= n_col_pos;
            r_ring      <= n_ring;
            r_pend_a    <= n_pend_a;
            r_pend_b    <= n_pend_b;
            r_pend_c    <= n_pend_c;
            r_rd_vld    <= n_rd_vld;
            r_m_valid   <= n_m_valid;
        end
    end

    // Job and payload registers.
    always_ff @(posedge i_clk) begin
        r_in_row   <= n_in_row;
        r_in_col   <= n_in_col;
        r_in_ring  <= n_in_ring;
        r_jcol     <= n_jcol;
        r_job_row  <= n_job_row;
        r_job_col  <= n_job_col;
        r_job_ring <= n_job_ring;
        r_job_last <= n_job_last;
        r_job_done <= n_job_done;
        r_di       <= n_di;
        r_dj       <= n_dj;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_mean     <= n_mean;
        r_m_data   <= n_m_data;
        r_m_last   <= n_m_last;
        r_m_user   <= n_m_user;
    end

    // Row store.
    nmf_row_mem #(
        .DEPTH (DEPTH)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (wr_addr),
        .i_wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Mean divider.
    assign div_req.valid = (r_state == ST_GO);
    assign div_req.sum   = r_sum;
    assign div_req.cnt   = r_cnt;

    nmf_mean_div u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

endmodule

### hdl/nmf_checker.sv
// ============================================================================
// nmf_checker - port-level checks for the neighbour mean filter
// Watches the stream ports of the top level and flags broken behavior.
// ============================================================================
module nmf_checker
    import nmf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic                 m_axis_tuser
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // The frame's last result also closes the run of its sample.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without end of run");

    // After taking a sample the block is busy in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample taken while still busy");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind neighbour_mean_filter_3x3 nmf_checker u_nmf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
